### rtl/core/fcbd_pkg.sv
// Shared constants, field layouts and request types of the fiber cluster bank decoder.
`default_nettype none

package fcbd_pkg;

    // Raw word layout: fraction in bit 0, channel above it, fragment flag above the channel.
    localparam int CH_BITS      = 7;
    localparam int DIFF_W       = CH_BITS + 1;
    localparam int MAX_CLUSTERS = 15;
    localparam int NUM_MODULES  = 6;
    localparam int MAX_DIST     = 128;

    localparam logic [3:0] WIDTH_MIN   = 4'd4;
    localparam logic [3:0] WIDTH_MAX   = 4'd8;
    localparam logic [3:0] WIDTH_RESET = 4'd4;

    localparam logic [4:0] SIZE_FRAGMENT = 5'd0;
    localparam logic [4:0] SIZE_ORDINARY = 5'd4;

    localparam logic [7:0] VER_PLAIN = 8'd2;
    localparam logic [7:0] VER_MERGE = 8'd3;

    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_VERSION = 2'd1;
    localparam logic [1:0] ERR_COUNT   = 2'd2;
    localparam logic [1:0] ERR_ORDER   = 2'd3;

    // Configuration port: a single 32-bit register, selected by the top address bit.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_CLUSTER_MAX_WIDTH = 1'b0;

    typedef struct packed {
        logic [15:0] word;
        logic        bank_start;
        logic [5:0]  bank_quarter;
        logic [7:0]  bank_version;
        logic [11:0] words_left;
    } t_in_item;

    typedef struct packed {
        logic [6:0] channel;
        logic       fraction;
        logic [4:0] pseudo_size;
        logic [5:0] quarter;
        logic [2:0] module_res;
        logic [3:0] sensor_index;
        logic [1:0] error;
        logic       last;
    } t_out_item;

    // Per-result part that changes within one request.
    typedef struct packed {
        logic [CH_BITS-1:0] channel;
        logic               fraction;
        logic [4:0]         pseudo_size;
        logic [1:0]         error;
    } t_result;

    typedef struct packed {
        logic load;
        logic step;
    } t_run_cmd;

    typedef struct packed {
        logic [CH_BITS-1:0] channel;
        logic               more;
    } t_run_stat;

endpackage

`default_nettype wire

### rtl/core/fiber_cluster_bank_decoder_core.sv
// Top level of the fiber cluster bank decoder: word parser, result sequencer and output register.
//
//  Channel   Direction  Handshake            Payload
//  in        input      i_in_valid/o_in_stall  i_in_item  (fcbd_pkg::t_in_item)
//  out       output     o_out_valid/i_out_stall o_out_item (fcbd_pkg::t_out_item)
//  config    input      psel/penable/pready  paddr, pwdata, prdata
//
// A request is taken in S_IDLE and decoded in S_DECODE; its results are then loaded into the
// output register one per cycle while it is not stalled (up to 33 for a split fragment run).
// The run length is set by the shared offset adder, one edge piece per cycle while not stalled.
// A result waiting in the output register does not block the next request.
// Reset is synchronous and active low; it clears the parser state and the register to 4.
`default_nettype none

module fiber_cluster_bank_decoder_core (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire fcbd_pkg::t_in_item              i_in_item,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output fcbd_pkg::t_out_item                  o_out_item,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [fcbd_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [fcbd_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [fcbd_pkg::APB_DATA_W-1:0] prdata,
    output logic                                 pready
);
    import fcbd_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_DECODE = 5'b00010,
        S_FIRST  = 5'b00100,
        S_RUN    = 5'b01000,
        S_FINAL  = 5'b10000
    } t_state;

    t_state             r_state, n_state;
    t_in_item           r_in;

    logic               r_expect_header, n_expect_header;
    logic [3:0]         r_clusters_left, n_clusters_left;
    logic               r_skipping, n_skipping;
    logic [2:0]         r_cur_module, n_cur_module;
    logic [3:0]         r_cur_sensor, n_cur_sensor;
    logic [5:0]         r_cur_quarter, n_cur_quarter;
    logic               r_merge_mode, n_merge_mode;
    logic               r_pending_valid, n_pending_valid;
    logic [CH_BITS-1:0] r_pending_channel, n_pending_channel;
    logic               r_pending_fraction, n_pending_fraction;
    logic               r_error_lock, n_error_lock;

    t_result            r_first, n_first;
    t_result            r_final, n_final;
    logic               r_has_run, n_has_run;
    logic               r_has_final, n_has_final;
    logic               dec_have;

    logic               r_out_valid;
    t_out_item          r_out_item;
    t_out_item          out_next;
    logic               out_free;
    logic               load_out;

    logic [3:0]         cluster_width;
    t_run_cmd           run_cmd;
    t_run_stat          run_stat;

    logic               in_fraction;
    logic [CH_BITS-1:0] in_channel;
    logic               in_flag;
    logic [DIFF_W-1:0]  diff;
    logic [4:0]         comb_wp1;
    logic [4:0]         comb_width;
    logic [4:0]         comb_wm1;
    logic [3:0]         half_cw;
    logic [CH_BITS-1:0] comb_pos;

    fcbd_apb_regs u_regs (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .o_cluster_width (cluster_width)
    );

    assign in_fraction = r_in.word[0];
    assign in_channel  = r_in.word[CH_BITS:1];
    assign in_flag     = r_in.word[CH_BITS+1];
    assign diff        = {1'b0, in_channel} - {1'b0, r_pending_channel};

    // Combined cluster: width is twice the distance plus the fraction, less one.
    assign comb_wp1   = {diff[3:0], in_fraction};
    assign comb_width = (comb_wp1 >= 5'd2) ? (comb_wp1 - 5'd1) : 5'd1;
    assign comb_wm1   = comb_width - 5'd1;
    assign half_cw    = 4'(cluster_width - 4'd1) >> 1;
    assign comb_pos   = r_pending_channel - CH_BITS'(half_cw) + CH_BITS'(comb_wm1 >> 1);

    fcbd_run_unit u_run (
        .i_clk   (i_clk),
        .i_cmd   (run_cmd),
        .i_base  (r_pending_channel),
        .i_width (cluster_width),
        .i_diff  (diff),
        .o_stat  (run_stat)
    );

    // Parser: next bank state and the plan of results for the request in r_in.
    always_comb begin
        logic lock_now;
        logic bad_ver;
        logic last_g;
        logic [3:0] cl_dec;

        n_expect_header    = r_expect_header;
        n_clusters_left    = r_clusters_left;
        n_skipping         = r_skipping;
        n_cur_module       = r_cur_module;
        n_cur_sensor       = r_cur_sensor;
        n_cur_quarter      = r_cur_quarter;
        n_merge_mode       = r_merge_mode;
        n_pending_valid    = r_pending_valid;
        n_pending_channel  = r_pending_channel;
        n_pending_fraction = r_pending_fraction;
        n_error_lock       = r_error_lock;
        n_first            = '0;
        n_final            = '0;
        n_has_run          = 1'b0;
        n_has_final        = 1'b0;
        dec_have           = 1'b0;
        bad_ver            = 1'b0;
        lock_now           = r_error_lock;
        last_g             = (r_clusters_left <= 4'd1);
        cl_dec             = last_g ? 4'd0 : (r_clusters_left - 4'd1);

        if (r_in.bank_start) begin
            n_expect_header = 1'b1;
            n_clusters_left = 4'd0;
            n_skipping      = 1'b0;
            n_pending_valid = 1'b0;
            n_error_lock    = 1'b0;
            lock_now        = 1'b0;
            n_cur_quarter   = r_in.bank_quarter;
            if (r_in.bank_version == VER_PLAIN) begin
                n_merge_mode = 1'b0;
            end else if (r_in.bank_version == VER_MERGE) begin
                n_merge_mode = 1'b1;
            end else begin
                bad_ver = 1'b1;
            end
        end

        if (bad_ver) begin
            n_error_lock  = 1'b1;
            dec_have      = 1'b1;
            n_first.error = ERR_VERSION;
        end else if (!lock_now) begin
            // The first word of a bank is always a header, even when a group was cut short.
            if (r_expect_header || r_in.bank_start) begin
                // A zero word at the very end of the bank is padding.
                if (!(r_in.word == 16'd0 && r_in.words_left == 12'd0)) begin
                    n_cur_sensor = r_in.word[7:4];
                    if ({8'd0, r_in.word[3:0]} > r_in.words_left) begin
                        n_error_lock    = 1'b1;
                        n_pending_valid = 1'b0;
                        dec_have        = 1'b1;
                        n_first.error   = ERR_COUNT;
                    end else if (r_in.word[3:0] != 4'd0) begin
                        n_clusters_left = r_in.word[3:0];
                        n_expect_header = 1'b0;
                        n_skipping      = (r_in.word[15:8] >= 8'(NUM_MODULES));
                        n_cur_module    = r_in.word[10:8];
                    end
                end
            end else begin
                n_clusters_left = cl_dec;
                if (cl_dec == 4'd0) begin
                    n_expect_header = 1'b1;
                end
                if (r_skipping) begin
                    if (cl_dec == 4'd0) begin
                        n_skipping = 1'b0;
                    end
                end else if (!r_merge_mode) begin
                    dec_have            = 1'b1;
                    n_first.channel     = in_channel;
                    n_first.fraction    = in_fraction;
                    n_first.pseudo_size = in_flag ? SIZE_FRAGMENT : SIZE_ORDINARY;
                end else if (r_pending_valid && in_flag) begin
                    n_pending_valid = 1'b0;
                    dec_have        = 1'b1;
                    if (in_channel < r_pending_channel || diff > DIFF_W'(MAX_DIST)) begin
                        n_error_lock  = 1'b1;
                        n_first.error = ERR_ORDER;
                    end else if (diff > DIFF_W'(cluster_width)) begin
                        // Too wide: both ends plus evenly spaced middle pieces.
                        n_first.channel     = r_pending_channel;
                        n_first.fraction    = r_pending_fraction;
                        n_first.pseudo_size = SIZE_FRAGMENT;
                        n_has_run           = 1'b1;
                        n_has_final         = 1'b1;
                        n_final.channel     = in_channel;
                        n_final.fraction    = in_fraction;
                        n_final.pseudo_size = SIZE_FRAGMENT;
                    end else begin
                        n_first.channel     = comb_pos;
                        n_first.fraction    = comb_wm1[0];
                        n_first.pseudo_size = comb_width;
                    end
                end else begin
                    if (r_pending_valid) begin
                        dec_have            = 1'b1;
                        n_pending_valid     = 1'b0;
                        n_first.channel     = r_pending_channel;
                        n_first.fraction    = r_pending_fraction;
                        n_first.pseudo_size = SIZE_ORDINARY;
                    end
                    if (!in_flag && !last_g) begin
                        n_pending_valid    = 1'b1;
                        n_pending_channel  = in_channel;
                        n_pending_fraction = in_fraction;
                    end else if (r_pending_valid) begin
                        n_has_final         = 1'b1;
                        n_final.channel     = in_channel;
                        n_final.fraction    = in_fraction;
                        n_final.pseudo_size = SIZE_ORDINARY;
                    end else begin
                        dec_have            = 1'b1;
                        n_first.channel     = in_channel;
                        n_first.fraction    = in_fraction;
                        n_first.pseudo_size = SIZE_ORDINARY;
                    end
                end
            end
        end
    end

    assign out_free = !r_out_valid || !i_out_stall;

    // Sequencer: first result, optional run of middle pieces, optional final result.
    always_comb begin
        n_state              = r_state;
        run_cmd              = '0;
        load_out             = 1'b0;
        out_next.channel     = r_first.channel;
        out_next.fraction    = r_first.fraction;
        out_next.pseudo_size = r_first.pseudo_size;
        out_next.error       = r_first.error;
        out_next.last        = !r_has_run && !r_has_final;
        out_next.quarter     = r_cur_quarter;
        out_next.module_res  = r_cur_module;
        out_next.sensor_index = r_cur_sensor;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                run_cmd.load = n_has_run;
                n_state      = dec_have ? S_FIRST : S_IDLE;
            end
            S_FIRST: begin
                if (out_free) begin
                    load_out = 1'b1;
                    if (r_has_run) begin
                        n_state = S_RUN;
                    end else if (r_has_final) begin
                        n_state = S_FINAL;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_RUN: begin
                out_next.channel     = run_stat.channel;
                out_next.fraction    = r_first.fraction;
                out_next.pseudo_size = SIZE_FRAGMENT;
                out_next.error       = ERR_NONE;
                out_next.last        = 1'b0;
                if (out_free) begin
                    load_out     = 1'b1;
                    run_cmd.step = 1'b1;
                    if (!run_stat.more) begin
                        n_state = S_FINAL;
                    end
                end
            end
            S_FINAL: begin
                out_next.channel     = r_final.channel;
                out_next.fraction    = r_final.fraction;
                out_next.pseudo_size = r_final.pseudo_size;
                out_next.error       = r_final.error;
                out_next.last        = 1'b1;
                if (out_free) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state            <= S_IDLE;
            r_expect_header    <= 1'b1;
            r_clusters_left    <= 4'd0;
            r_skipping         <= 1'b0;
            r_cur_module       <= 3'd0;
            r_cur_sensor       <= 4'd0;
            r_cur_quarter      <= 6'd0;
            r_merge_mode       <= 1'b0;
            r_pending_valid    <= 1'b0;
            r_pending_channel  <= '0;
            r_pending_fraction <= 1'b0;
            r_error_lock       <= 1'b0;
            r_has_run          <= 1'b0;
            r_has_final        <= 1'b0;
            r_out_valid        <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_DECODE) begin
                r_expect_header    <= n_expect_header;
                r_clusters_left    <= n_clusters_left;
                r_skipping         <= n_skipping;
                r_cur_module       <= n_cur_module;
                r_cur_sensor       <= n_cur_sensor;
                r_cur_quarter      <= n_cur_quarter;
                r_merge_mode       <= n_merge_mode;
                r_pending_valid    <= n_pending_valid;
                r_pending_channel  <= n_pending_channel;
                r_pending_fraction <= n_pending_fraction;
                r_error_lock       <= n_error_lock;
                r_has_run          <= n_has_run;
                r_has_final        <= n_has_final;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in_valid) begin
            r_in <= i_in_item;
        end
        if (r_state == S_DECODE) begin
            r_first <= n_first;
            r_final <= n_final;
        end
        if (load_out) begin
            r_out_item <= out_next;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // An error always ends the results of its request.
    a_error_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.error != ERR_NONE) |-> o_out_item.last)
        else $error("error result without last");

    // A held word exists only in banks that merge fragments.
    a_pending_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending_valid |-> r_merge_mode)
        else $error("held word outside merge mode");

    // A locked bank never keeps a held word.
    a_lock_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_error_lock |-> !r_pending_valid)
        else $error("held word while locked");

    // A run of middle pieces always closes with the far edge.
    a_run_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> r_has_final)
        else $error("fragment run without closing edge");

    // The output register is only refilled once the previous result has been taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_item)))
        else $error("stalled result overwritten");

endmodule

`default_nettype wire

### rtl/core/fcbd_apb_regs.sv
// Configuration register file with the saturated cluster width used by the datapath.
`default_nettype none

module fcbd_apb_regs (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [fcbd_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [fcbd_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [fcbd_pkg::APB_DATA_W-1:0] prdata,
    output logic                                 pready,
    output logic      [3:0]                      o_cluster_width
);
    import fcbd_pkg::*;

    logic [3:0] r_max_width;
    logic       reg_hit;

    assign reg_hit = (paddr[APB_ADDR_W-1] == REG_CLUSTER_MAX_WIDTH);
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_width <= WIDTH_RESET;
        end else if (psel && penable && pwrite && pready && reg_hit) begin
            r_max_width <= pwdata[3:0];
        end
    end

    assign prdata = reg_hit ? {{(APB_DATA_W-4){1'b0}}, r_max_width} : '0;

    always_comb begin
        if (r_max_width < WIDTH_MIN) begin
            o_cluster_width = WIDTH_MIN;
        end else if (r_max_width > WIDTH_MAX) begin
            o_cluster_width = WIDTH_MAX;
        end else begin
            o_cluster_width = r_max_width;
        end
    end

endmodule

`default_nettype wire

### rtl/core/fcbd_run_unit.sv
// Shared offset adder and compare that walks the edge positions of a split fragment run.
`default_nettype none

module fcbd_run_unit (
    input  wire logic                         i_clk,
    input  wire fcbd_pkg::t_run_cmd           i_cmd,
    input  wire logic [fcbd_pkg::CH_BITS-1:0] i_base,
    input  wire logic [3:0]                   i_width,
    input  wire logic [fcbd_pkg::DIFF_W-1:0]  i_diff,
    output fcbd_pkg::t_run_stat               o_stat
);
    import fcbd_pkg::*;

    logic [CH_BITS-1:0] r_base;
    logic [3:0]         r_width;
    logic [DIFF_W-1:0]  r_diff;
    logic [DIFF_W-1:0]  r_off;
    logic [DIFF_W:0]    next_off;

    // The offset never passes the distance plus one step, so one extra bit holds the sum.
    assign next_off = {1'b0, r_off} + (DIFF_W+1)'(r_width);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_base  <= i_base;
            r_width <= i_width;
            r_diff  <= i_diff;
            r_off   <= DIFF_W'(i_width);
        end else if (i_cmd.step) begin
            r_off <= next_off[DIFF_W-1:0];
        end
    end

    assign o_stat.channel = r_base + r_off[CH_BITS-1:0];
    assign o_stat.more    = (next_off < {1'b0, r_diff});

endmodule

`default_nettype wire

### tb/tb_fiber_cluster_bank_decoder_core.sv
// Self-checking testbench for the fiber cluster bank decoder core.
`default_nettype none

module tb_fiber_cluster_bank_decoder_core;

    import fcbd_pkg::*;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 50;
    localparam logic [APB_ADDR_W-1:0] WIDTH_ADDR = APB_ADDR_W'(4 * REG_CLUSTER_MAX_WIDTH);

    logic clk = 1'b0;
    logic rst_n;

    logic      in_valid;
    logic      in_stall;
    t_in_item  in_item;
    logic      out_valid;
    logic      out_stall;
    t_out_item out_item;

    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // Decoder state as predicted from the accepted requests.
    logic [3:0] width_cfg   = WIDTH_RESET;
    logic       exp_hdr     = 1'b1;
    logic [3:0] grp_left    = '0;
    logic       skip_grp    = 1'b0;
    logic [2:0] mod_cur     = '0;
    logic [3:0] sens_cur    = '0;
    logic [5:0] quarter_cur = '0;
    logic       merge_on    = 1'b0;
    logic       held_valid  = 1'b0;
    logic [6:0] held_ch     = '0;
    logic       held_fr     = 1'b0;
    logic       locked      = 1'b0;

    t_out_item step_clusters[$];
    t_out_item expected_clusters[$];

    int  mismatches  = 0;
    int  items_sent  = 0;
    int  cycle_count = 0;
    int  hold_left   = 0;
    bit  steady      = 1'b0;

    fiber_cluster_bank_decoder_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #5 clk = ~clk;

    function automatic string fmt_cluster(t_out_item c);
        return $sformatf("ch=%0d fr=%0d size=%0d q=%0d mod=%0d sens=%0d err=%0d last=%0d",
                         c.channel, c.fraction, c.pseudo_size, c.quarter, c.module_res,
                         c.sensor_index, c.error, c.last);
    endfunction

    task automatic note_mismatch(input string what, input string want, input string got);
        mismatches++;
        if (mismatches <= 10)
            $display("MISMATCH %s: expected %s, got %s", what, want, got);
    endtask

    function automatic t_in_item mk_request(logic [15:0] word, logic start, logic [5:0] quarter,
                                            logic [7:0] version, logic [11:0] left);
        t_in_item it;
        it.word         = word;
        it.bank_start   = start;
        it.bank_quarter = quarter;
        it.bank_version = version;
        it.words_left   = left;
        return it;
    endfunction

    task automatic add_cluster(input logic [6:0] ch, input logic fr, input logic [4:0] size,
                               input logic [1:0] err);
        t_out_item c;
        c.channel      = ch;
        c.fraction     = fr;
        c.pseudo_size  = size;
        c.quarter      = quarter_cur;
        c.module_res   = mod_cur;
        c.sensor_index = sens_cur;
        c.error        = err;
        c.last         = 1'b0;
        step_clusters.insert(step_clusters.size(), c);
    endtask

    task automatic flag_error(input logic [1:0] err);
        locked     = 1'b1;
        held_valid = 1'b0;
        add_cluster('0, 1'b0, '0, err);
    endtask

    // Advances the predicted state by one raw word and leaves its clusters in step_clusters.
    task automatic predict_clusters(input t_in_item it);
        logic [6:0] ch;
        logic       fr;
        logic       fl;
        logic       last_grp;
        int         cnt;
        int         modv;
        int         w;
        int         diff;
        int         wid;
        int         pos;
        step_clusters.delete();
        if (it.bank_start) begin
            exp_hdr     = 1'b1;
            grp_left    = '0;
            skip_grp    = 1'b0;
            held_valid  = 1'b0;
            locked      = 1'b0;
            quarter_cur = it.bank_quarter;
            if (it.bank_version == VER_PLAIN) begin
                merge_on = 1'b0;
            end else if (it.bank_version == VER_MERGE) begin
                merge_on = 1'b1;
            end else begin
                flag_error(ERR_VERSION);
                return;
            end
        end
        if (locked)
            return;

        if (exp_hdr) begin
            // A zero word at the very end of the bank is padding.
            if (it.word == 16'd0 && it.words_left == 12'd0)
                return;
            cnt      = it.word[3:0];
            sens_cur = it.word[7:4];
            modv     = it.word[15:8];
            if (cnt > it.words_left) begin
                flag_error(ERR_COUNT);
                return;
            end
            if (cnt == 0)
                return;
            grp_left = 4'(cnt);
            exp_hdr  = 1'b0;
            skip_grp = (modv >= NUM_MODULES);
            mod_cur  = it.word[10:8];
            return;
        end

        last_grp = (grp_left <= 1);
        grp_left = last_grp ? 4'd0 : grp_left - 4'd1;
        if (grp_left == 0)
            exp_hdr = 1'b1;
        if (skip_grp) begin
            if (grp_left == 0)
                skip_grp = 1'b0;
            return;
        end

        fr = it.word[0];
        ch = it.word[CH_BITS:1];
        fl = it.word[CH_BITS+1];

        if (!merge_on) begin
            add_cluster(ch, fr, fl ? SIZE_FRAGMENT : SIZE_ORDINARY, ERR_NONE);
        end else if (held_valid && fl) begin
            // The held word and the flagged end fragment form one cluster or an edge run.
            held_valid = 1'b0;
            diff = int'(ch) - int'(held_ch);
            if (ch < held_ch || diff > MAX_DIST) begin
                flag_error(ERR_ORDER);
            end else begin
                w = width_cfg;
                if (w < WIDTH_MIN)
                    w = WIDTH_MIN;
                if (w > WIDTH_MAX)
                    w = WIDTH_MAX;
                if (diff > w) begin
                    add_cluster(held_ch, held_fr, SIZE_FRAGMENT, ERR_NONE);
                    for (int i = w; i < diff; i += w)
                        add_cluster(7'(int'(held_ch) + i), held_fr, SIZE_FRAGMENT, ERR_NONE);
                    add_cluster(ch, fr, SIZE_FRAGMENT, ERR_NONE);
                end else begin
                    wid = 2 * diff + fr;
                    wid = (wid >= 2) ? wid - 1 : 1;
                    pos = int'(held_ch) - (w - 1) / 2 + (wid - 1) / 2;
                    add_cluster(7'(pos), 1'(wid - 1), 5'(wid), ERR_NONE);
                end
            end
        end else begin
            if (held_valid) begin
                add_cluster(held_ch, held_fr, SIZE_ORDINARY, ERR_NONE);
                held_valid = 1'b0;
            end
            if (!fl && !last_grp) begin
                held_valid = 1'b1;
                held_ch    = ch;
                held_fr    = fr;
            end else begin
                add_cluster(ch, fr, SIZE_ORDINARY, ERR_NONE);
            end
        end
    endtask

    // Offers one request and returns at the edge where it was accepted.
    task automatic send_word(input t_in_item it);
        while (!steady && $urandom_range(99) < 35) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_clusters(it);
        if (step_clusters.size() > 0)
            step_clusters[step_clusters.size()-1].last = 1'b1;
        foreach (step_clusters[k])
            expected_clusters.insert(expected_clusters.size(), step_clusters[k]);
        items_sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_clusters.size() != 0)
            @(posedge clk);
        // Requests that give no cluster may still be in flight.
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_cluster_width(input logic [3:0] value);
        wait_drained();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= WIDTH_ADDR;
        pwdata  <= APB_DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== APB_DATA_W'(value))
            note_mismatch("width readback", $sformatf("%0d", value), $sformatf("%0d", prdata));
        psel    <= 1'b0;
        penable <= 1'b0;
        width_cfg = value;
    endtask

    // One bank of header groups, with padding, truncation, bad versions and stray words mixed in.
    task automatic send_random_bank(input int merge_pct);
        logic [15:0] words[$];
        logic [7:0]  ver;
        logic [6:0]  prev_ch;
        logic [6:0]  ch;
        logic        flag;
        int          roll;
        int          cnt;
        int          modv;
        int          d;
        int          n;
        int          cut;
        t_in_item    it;
        roll = $urandom_range(99);
        if (roll < 4) begin
            repeat ($urandom_range(1, 4)) begin
                it = mk_request(16'($urandom), 1'b0, 6'($urandom), 8'($urandom), 12'($urandom));
                send_word(it);
            end
            return;
        end
        if (roll < 8)
            ver = 8'($urandom_range(255));
        else
            ver = ($urandom_range(99) < merge_pct) ? VER_MERGE : VER_PLAIN;

        prev_ch = 7'($urandom);
        repeat ($urandom_range(1, 3)) begin
            cnt  = ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(1, 6);
            modv = ($urandom_range(9) == 0) ? $urandom_range(6, 255) : $urandom_range(5);
            words.insert(words.size(), {8'(modv), 4'($urandom), 4'(cnt)});
            repeat (cnt) begin
                flag = ($urandom_range(99) < 35);
                roll = $urandom_range(9);
                if (flag && roll < 9) begin
                    d = (roll < 6) ? $urandom_range(10) : $urandom_range(127);
                    if (int'(prev_ch) + d > 127)
                        d = 127 - prev_ch;
                    ch = 7'(int'(prev_ch) + d);
                end else begin
                    ch = 7'($urandom);
                end
                words.insert(words.size(), {7'($urandom), flag, ch, 1'($urandom)});
                prev_ch = ch;
            end
        end
        if ($urandom_range(3) == 0)
            repeat ($urandom_range(1, 2)) words.insert(words.size(), 16'd0);
        if ($urandom_range(11) == 0 && words.size() > 1) begin
            cut = $urandom_range(1, words.size() - 1);
            while (words.size() > cut)
                void'(words.pop_back());
        end

        n = words.size();
        foreach (words[k]) begin
            if (k == 0)
                it = mk_request(words[k], 1'b1,
                                ($urandom_range(9) == 0) ? 6'($urandom) : 6'($urandom_range(47)),
                                ver, 12'(n - 1));
            else
                it = mk_request(words[k], 1'b0, 6'($urandom), 8'($urandom), 12'(n - 1 - k));
            send_word(it);
        end
    endtask

    task automatic test_directed_cases();
        // Words ahead of any bank decode as version 2.
        send_word(mk_request(16'h0131, 1'b0, 6'd0, 8'd0, 12'd4095));
        send_word(mk_request(16'hFFFF, 1'b0, 6'd63, 8'hFF, 12'd4094));
        // Unsupported version, then a word dropped while locked.
        send_word(mk_request(16'h0101, 1'b1, 6'd63, 8'hFF, 12'd1));
        send_word(mk_request(16'h0012, 1'b0, 6'd0, 8'd0, 12'd0));
        // Plain bank: ordinary cluster, fragment piece and trailing padding.
        send_word(mk_request(16'h05F2, 1'b1, 6'd47, VER_PLAIN, 12'd3));
        send_word(mk_request(16'h0000, 1'b0, 6'd0, 8'd0, 12'd2));
        send_word(mk_request(16'h0100, 1'b0, 6'd0, 8'd0, 12'd1));
        send_word(mk_request(16'h0000, 1'b0, 6'd0, 8'd0, 12'd0));
        // Module out of range is skipped; then a count that overruns the bank.
        send_word(mk_request(16'hFF41, 1'b1, 6'd1, VER_PLAIN, 12'd2));
        send_word(mk_request(16'h00AA, 1'b0, 6'd0, 8'd0, 12'd1));
        send_word(mk_request(16'h0013, 1'b0, 6'd0, 8'd0, 12'd0));
        // A held word is dropped when a new bank cuts its group short.
        send_word(mk_request(16'h0204, 1'b1, 6'd20, VER_MERGE, 12'd10));
        send_word(mk_request(16'h0014, 1'b0, 6'd0, 8'd0, 12'd9));
        // Degenerate merge, long edge run, and a held word flushed by the group end.
        send_word(mk_request(16'h02F6, 1'b1, 6'd5, VER_MERGE, 12'd6));
        send_word(mk_request(16'h0014, 1'b0, 6'd0, 8'd0, 12'd5));
        send_word(mk_request(16'h0114, 1'b0, 6'd0, 8'd0, 12'd4));
        send_word(mk_request(16'h0029, 1'b0, 6'd0, 8'd0, 12'd3));
        send_word(mk_request(16'h0179, 1'b0, 6'd0, 8'd0, 12'd2));
        send_word(mk_request(16'h00C8, 1'b0, 6'd0, 8'd0, 12'd1));
        send_word(mk_request(16'h00FF, 1'b0, 6'd0, 8'd0, 12'd0));
        // Lone fragment, merge with fraction, and a fragment below the held channel.
        send_word(mk_request(16'h0035, 1'b1, 6'd0, VER_MERGE, 12'd5));
        send_word(mk_request(16'h0101, 1'b0, 6'd0, 8'd0, 12'd4));
        send_word(mk_request(16'h000B, 1'b0, 6'd0, 8'd0, 12'd3));
        send_word(mk_request(16'h0111, 1'b0, 6'd0, 8'd0, 12'd2));
        send_word(mk_request(16'h0064, 1'b0, 6'd0, 8'd0, 12'd1));
        send_word(mk_request(16'h0150, 1'b0, 6'd0, 8'd0, 12'd0));
    endtask

    task automatic test_fragment_widths();
        logic [3:0] widths[8] = '{4'd8, 4'd0, 4'd15, 4'd6, 4'd5, 4'd7, 4'd9, 4'd4};
        int         target;
        foreach (widths[k]) begin
            set_cluster_width(widths[k]);
            target = items_sent + 14;
            while (items_sent < target)
                send_random_bank(90);
        end
    endtask

    task automatic test_random_banks();
        int target;
        set_cluster_width(4'($urandom_range(4, 8)));
        steady = 1'b1;
        target = items_sent + 50;
        while (items_sent < target)
            send_random_bank(60);
        steady = 1'b0;
        target = items_sent + 90;
        while (items_sent < target)
            send_random_bank(60);
    endtask

    task automatic test_output_holdoff();
        int target;
        // The receiver stalls on its own while requests keep coming, so the core backs up.
        hold_left = 400;
        target = items_sent + 30;
        while (items_sent < target)
            send_random_bank(80);
    endtask

    always @(posedge clk) begin
        if (hold_left > 0) begin
            out_stall <= 1'b1;
            hold_left = hold_left - 1;
        end else begin
            out_stall <= !steady && ($urandom_range(99) < 35);
        end
    end

    always @(posedge clk) begin : check_clusters
        t_out_item want;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_clusters.size() == 0) begin
                note_mismatch("unexpected cluster", "none", fmt_cluster(out_item));
            end else begin
                want = expected_clusters.pop_front();
                if (out_item !== want)
                    note_mismatch("cluster", fmt_cluster(want), fmt_cluster(out_item));
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_item  = '0;
        out_stall = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        test_directed_cases();
        test_fragment_widths();
        test_random_banks();
        test_output_holdoff();

        wait_drained();
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire
